FILE: design/pfe_pkg.sv
package pfe_pkg;

   localparam int CHAR_WIDTH     = 8;
   localparam int OUT_CHAR_WIDTH = 7;
   localparam int CODE_WIDTH     = 5;
   localparam int KEY_SIDE       = 5;
   localparam int IDX_WIDTH      = 3;
   localparam int CSR_DATA_WIDTH = 50;
   localparam int CSR_IDX_WIDTH  = 2;
   localparam int ROW_PAIR_WIDTH = 50;
   localparam int ROW_ONE_WIDTH  = 25;

   localparam logic [CODE_WIDTH-1:0] CODE_I = 5'd8;
   localparam logic [CODE_WIDTH-1:0] CODE_J = 5'd9;
   localparam logic [CODE_WIDTH-1:0] CODE_Z = 5'd25;

   localparam logic [CHAR_WIDTH-1:0] ASCII_UPPER_LO = 8'd64;
   localparam logic [CHAR_WIDTH-1:0] ASCII_UPPER_HI = 8'd91;
   localparam logic [CHAR_WIDTH-1:0] ASCII_CASE_GAP = 8'd32;
   localparam logic [CHAR_WIDTH-1:0] ASCII_LOWER_A  = 8'd97;
   localparam logic [CHAR_WIDTH-1:0] ASCII_LOWER_Z  = 8'd122;

   typedef enum logic [CSR_IDX_WIDTH-1:0] {
      CSR_KEY_ROWS_ZERO_ONE  = 2'd0,
      CSR_KEY_ROWS_TWO_THREE = 2'd1,
      CSR_KEY_ROW_FOUR       = 2'd2
   } csr_index_type;

   typedef logic [CODE_WIDTH-1:0] code_type;
   typedef logic [KEY_SIDE-1:0][KEY_SIDE-1:0][CODE_WIDTH-1:0] key_table_type;

   typedef struct packed {
      logic [IDX_WIDTH-1:0] row;
      logic [IDX_WIDTH-1:0] col;
   } pos_type;

   typedef struct packed {
      code_type first;
      code_type second;
      logic     last;
   } pair_type;

   // Later table entries win on duplicates; a missing letter lands at row 0, column 0.
   function automatic pos_type find_pos(key_table_type tbl, code_type code);
      pos_type pos;
      pos = '0;
      for (int r = 0; r < KEY_SIDE; r++) begin
         for (int c = 0; c < KEY_SIDE; c++) begin
            if (tbl[r][c] == code) begin
               pos.row = IDX_WIDTH'(r);
               pos.col = IDX_WIDTH'(c);
            end
         end
      end
      return pos;
   endfunction

   function automatic logic [IDX_WIDTH-1:0] wrap_inc(logic [IDX_WIDTH-1:0] v);
      logic [IDX_WIDTH-1:0] nxt;
      if (v == IDX_WIDTH'(KEY_SIDE - 1)) begin
         nxt = '0;
      end else begin
         nxt = v + 1'b1;
      end
      return nxt;
   endfunction

   function automatic logic [OUT_CHAR_WIDTH-1:0] code_to_char(code_type code);
      code_type clip;
      clip = (code > CODE_Z) ? CODE_Z : code;
      return ASCII_LOWER_A[OUT_CHAR_WIDTH-1:0] + {{(OUT_CHAR_WIDTH-CODE_WIDTH){1'b0}}, clip};
   endfunction

endpackage

FILE: design/pfe_if.sv
interface pfe_req_if import pfe_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CHAR_WIDTH-1:0] in_char;
   logic                  in_last;

   modport source (output valid, in_char, in_last, input ready);
   modport sink   (input valid, in_char, in_last, output ready);
endinterface

interface pfe_rsp_if import pfe_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [OUT_CHAR_WIDTH-1:0] out_char;
   logic                      out_last;

   modport source (output valid, out_char, out_last, input ready);
   modport sink   (input valid, out_char, out_last, output ready);
endinterface

FILE: design/pfe_front.sv
module pfe_front import pfe_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   pfe_req_if.sink  req_chan,
   input  logic     pair_ready,
   output logic     pair_valid,
   output pair_type pair_data
);

   logic     pending_valid_ff, pending_valid_in;
   code_type pending_letter_ff, pending_letter_in;
   logic     pair_valid_ff, pair_valid_in;
   pair_type pair_ff, pair_in;

   logic [CHAR_WIDTH-1:0] folded;
   logic                  is_letter;
   code_type              code;
   logic                  accept;

   assign req_chan.ready = !pair_valid_ff || pair_ready;
   assign accept         = req_chan.valid && req_chan.ready;
   assign pair_valid     = pair_valid_ff;
   assign pair_data      = pair_ff;

   always_comb begin
      folded = req_chan.in_char;
      if (req_chan.in_char > ASCII_UPPER_LO && req_chan.in_char < ASCII_UPPER_HI) begin
         folded = req_chan.in_char + ASCII_CASE_GAP;
      end
      is_letter = (folded >= ASCII_LOWER_A) && (folded <= ASCII_LOWER_Z);
      code      = CODE_WIDTH'(folded - ASCII_LOWER_A);
      if (code == CODE_J) begin
         code = CODE_I;
      end
   end

   always_comb begin
      pending_valid_in  = pending_valid_ff;
      pending_letter_in = pending_letter_ff;
      pair_valid_in     = pair_valid_ff && !pair_ready;
      pair_in           = pair_ff;
      if (accept) begin
         if (is_letter && pending_valid_ff) begin
            pair_valid_in    = 1'b1;
            pair_in          = '{first: pending_letter_ff, second: code,
                                 last: req_chan.in_last};
            pending_valid_in = 1'b0;
         end else if (is_letter && !req_chan.in_last) begin
            pending_valid_in  = 1'b1;
            pending_letter_in = code;
         end else if (is_letter) begin
            pair_valid_in = 1'b1;
            pair_in       = '{first: code, second: CODE_Z, last: 1'b1};
         end else if (req_chan.in_last && pending_valid_ff) begin
            // pad the odd letter at end of message
            pair_valid_in    = 1'b1;
            pair_in          = '{first: pending_letter_ff, second: CODE_Z, last: 1'b1};
            pending_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_valid_ff  <= 1'b0;
         pending_letter_ff <= '0;
         pair_valid_ff     <= 1'b0;
      end else begin
         pending_valid_ff  <= pending_valid_in;
         pending_letter_ff <= pending_letter_in;
         pair_valid_ff     <= pair_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pair_ff <= pair_in;
   end

endmodule

FILE: design/pfe_encrypt.sv
module pfe_encrypt import pfe_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  key_table_type key_table,
   input  logic          pair_valid,
   input  pair_type      pair_data,
   output logic          pair_ready,
   pfe_rsp_if.source     rsp_chan
);

   logic                      out_valid_ff, out_valid_in;
   logic                      second_ff, second_in;
   logic [OUT_CHAR_WIDTH-1:0] char_a_ff, char_a_in;
   logic [OUT_CHAR_WIDTH-1:0] char_b_ff, char_b_in;
   logic                      last_ff, last_in;

   pos_type pa, pb, ea, eb;
   logic    load;
   logic    rsp_accept;

   assign rsp_accept = rsp_chan.valid && rsp_chan.ready;
   assign pair_ready = !out_valid_ff || (second_ff && rsp_chan.ready);
   assign load       = pair_valid && pair_ready;

   assign rsp_chan.valid    = out_valid_ff;
   assign rsp_chan.out_char = second_ff ? char_b_ff : char_a_ff;
   assign rsp_chan.out_last = second_ff && last_ff;

   always_comb begin
      pa = find_pos(key_table, pair_data.first);
      pb = find_pos(key_table, pair_data.second);
      if (pa.row == pb.row) begin
         ea = '{row: pa.row, col: wrap_inc(pa.col)};
         eb = '{row: pb.row, col: wrap_inc(pb.col)};
      end else if (pa.col == pb.col) begin
         ea = '{row: wrap_inc(pa.row), col: pa.col};
         eb = '{row: wrap_inc(pb.row), col: pb.col};
      end else begin
         ea = '{row: pa.row, col: pb.col};
         eb = '{row: pb.row, col: pa.col};
      end
      char_a_in = code_to_char(key_table[ea.row][ea.col]);
      char_b_in = code_to_char(key_table[eb.row][eb.col]);
      last_in   = pair_data.last;
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      second_in    = second_ff;
      if (load) begin
         out_valid_in = 1'b1;
         second_in    = 1'b0;
      end else if (rsp_accept) begin
         // first letter taken: advance to second; second taken: drop the pair
         out_valid_in = !second_ff;
         second_in    = !second_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         second_ff    <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         second_ff    <= second_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         char_a_ff <= char_a_in;
         char_b_ff <= char_b_in;
         last_ff   <= last_in;
      end
   end

endmodule

FILE: design/playfair_digraph_encrypt_core.sv
// Playfair encryptor over a 5x5 key table loaded through the csr_ port. One plaintext
// character is taken per cycle unless a waiting pair stalls the input; letters are case
// folded, j maps to i, everything else is dropped, and each completed pair (or an odd
// last letter padded with z) yields two ciphertext letters, the second carrying
// out_last at end of message. A pair goes through one register stage for pairing and
// one for table lookup, so the first letter of a pair passes the pairing register and
// then the lookup register before it shows on rsp_chan. The output stage hands out
// the two letters of a pair one after the other and can load the next pair as its
// second letter is taken; a burst of pairs (many one-letter messages) is held back by
// that output stage, which then stalls the input. The key table must be written
// while no request is in flight.
module playfair_digraph_encrypt_core import pfe_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   pfe_req_if.sink                   req_chan,
   pfe_rsp_if.source                 rsp_chan,
   input  logic                      csr_write_enable,
   input  logic [CSR_IDX_WIDTH-1:0]  csr_index,
   input  logic [CSR_DATA_WIDTH-1:0] csr_data
);

   logic [ROW_PAIR_WIDTH-1:0] key_rows_zero_one_ff, key_rows_zero_one_in;
   logic [ROW_PAIR_WIDTH-1:0] key_rows_two_three_ff, key_rows_two_three_in;
   logic [ROW_ONE_WIDTH-1:0]  key_row_four_ff, key_row_four_in;

   key_table_type key_table;
   logic          pair_valid;
   logic          pair_ready;
   pair_type      pair_data;

   always_comb begin
      key_rows_zero_one_in  = key_rows_zero_one_ff;
      key_rows_two_three_in = key_rows_two_three_ff;
      key_row_four_in       = key_row_four_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_KEY_ROWS_ZERO_ONE:  key_rows_zero_one_in  = csr_data[ROW_PAIR_WIDTH-1:0];
            CSR_KEY_ROWS_TWO_THREE: key_rows_two_three_in = csr_data[ROW_PAIR_WIDTH-1:0];
            CSR_KEY_ROW_FOUR:       key_row_four_in       = csr_data[ROW_ONE_WIDTH-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_rows_zero_one_ff  <= '0;
         key_rows_two_three_ff <= '0;
         key_row_four_ff       <= '0;
      end else begin
         key_rows_zero_one_ff  <= key_rows_zero_one_in;
         key_rows_two_three_ff <= key_rows_two_three_in;
         key_row_four_ff       <= key_row_four_in;
      end
   end

   always_comb begin
      for (int c = 0; c < KEY_SIDE; c++) begin
         key_table[0][c] = key_rows_zero_one_ff[c*CODE_WIDTH +: CODE_WIDTH];
         key_table[1][c] = key_rows_zero_one_ff[(KEY_SIDE+c)*CODE_WIDTH +: CODE_WIDTH];
         key_table[2][c] = key_rows_two_three_ff[c*CODE_WIDTH +: CODE_WIDTH];
         key_table[3][c] = key_rows_two_three_ff[(KEY_SIDE+c)*CODE_WIDTH +: CODE_WIDTH];
         key_table[4][c] = key_row_four_ff[c*CODE_WIDTH +: CODE_WIDTH];
      end
   end

   pfe_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .pair_ready (pair_ready),
      .pair_valid (pair_valid),
      .pair_data  (pair_data)
   );

   pfe_encrypt u_encrypt (
      .clock      (clock),
      .reset      (reset),
      .key_table  (key_table),
      .pair_valid (pair_valid),
      .pair_data  (pair_data),
      .pair_ready (pair_ready),
      .rsp_chan   (rsp_chan)
   );

endmodule

FILE: design/pfe_checker.sv
module pfe_checker import pfe_pkg::*; (
   input logic                      clock,
   input logic                      reset,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic [OUT_CHAR_WIDTH-1:0] rsp_char,
   input logic                      rsp_last
);

   logic odd_ff, odd_in;

   // track position within a pair of results
   assign odd_in = (rsp_valid && rsp_ready) ? !odd_ff : odd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         odd_ff <= 1'b0;
      end else begin
         odd_ff <= odd_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_char) && $stable(rsp_last))
      else $error("stalled result changed");

   a_rsp_letter: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_char >= ASCII_LOWER_A[OUT_CHAR_WIDTH-1:0]
                 && rsp_char <= ASCII_LOWER_Z[OUT_CHAR_WIDTH-1:0])
      else $error("result is not a lowercase letter");

   a_last_on_second: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> odd_ff)
      else $error("end of message marked on first letter of a pair");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind playfair_digraph_encrypt_core pfe_checker u_pfe_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_char  (rsp_chan.out_char),
   .rsp_last  (rsp_chan.out_last)
);
